// ===== rtl/utf8_stream_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared helpers that wrap concurrent assertions in the house form.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define U8SD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8_stream_decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8_stream_decoder: next-cycle check failed");

`endif

// ===== rtl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Beat types and byte-class constants shared by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8sd_pkg;

   localparam int CODE_W = 21;

   localparam logic [CODE_W-1:0] ILLEGAL_CODE = 21'h00FFFF;

   // Byte classes: (byte & MASK) == TAG.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // Payload bits carried by each byte class.
   localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;
   localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
   localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
   localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;

   // Sequence lengths.
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_beat_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              is_illegal;
      logic              run_end;
   } rsp_beat_type;

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Turns a stream of UTF-8 bytes into a stream of 21-bit code points.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per beat and returns zero to four code point
// beats for it. A plain ASCII byte or a byte that completes a sequence gives
// one beat, a lead or middle byte of an open sequence gives none, and an error
// gives a burst of illegal beats (code 0xFFFF), one for each byte that cannot
// be decoded, with run_end set on the last beat caused by the byte. Bytes move
// through an input register, one level of decode logic, and a result register
// that plays out the burst. A byte whose burst is one beat long or empty is
// taken every cycle unless the output stalls; a longer burst holds the result
// register until its final beat leaves, and a next byte with results stalls
// behind it. While a finished result waits on a stalled output, the input
// register takes a byte only if it is empty or its byte gives no results.
`timescale 1ns / 1ps

`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   // Input register.
   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff;

   // Result burst register: beats left to send and the final beat's value.
   // All beats before the final one are illegal.
   logic              burst_valid_ff, burst_valid_in;
   logic [2:0]        burst_left_ff, burst_left_in;
   logic [CODE_W-1:0] tail_code_ff, tail_code_in;
   logic              tail_illegal_ff, tail_illegal_in;

   // Decoder state for the open sequence.
   logic [1:0]        held_ff, held_in;
   logic [2:0]        expected_ff, expected_in;
   logic [CODE_W-1:0] partial_ff, partial_in;

   logic              req_take;
   logic              rsp_take;
   logic              burst_free;
   logic              advance;

   logic [7:0]        cur_byte;
   logic              cur_last;

   // Result of decoding the current byte as if no sequence were open.
   logic              f_count;
   logic [CODE_W-1:0] f_code;
   logic              f_illegal;
   logic              f_open;
   logic [2:0]        f_len;
   logic [CODE_W-1:0] f_payload;

   logic [2:0]        held_plus;
   logic [CODE_W-1:0] cont_code;
   logic              is_cont;

   logic [2:0]        dec_count;
   logic [CODE_W-1:0] dec_code;
   logic              dec_illegal;

   assign cur_byte = in_beat_ff.text_byte;
   assign cur_last = in_beat_ff.final_byte;

   // The burst register can take a new burst when it is empty or its final
   // beat leaves in this cycle.
   assign rsp_take   = burst_valid_ff && !rsp_stall;
   assign burst_free = !burst_valid_ff || (rsp_take && burst_left_ff == 3'd1);

   // Decode of a byte with no sequence open.
   always_comb begin
      f_count   = 1'b1;
      f_code    = ILLEGAL_CODE;
      f_illegal = 1'b1;
      f_open    = 1'b0;
      f_len     = '0;
      f_payload = '0;
      if (!cur_byte[7]) begin
         f_code    = {13'd0, cur_byte};
         f_illegal = 1'b0;
      end else if (cur_last) begin
         // A lead byte at the end of the text cannot complete.
         f_code    = ILLEGAL_CODE;
      end else if ((cur_byte & LEAD2_MASK) == LEAD2_TAG) begin
         f_count   = 1'b0;
         f_open    = 1'b1;
         f_len     = SEQ_LEN2;
         f_payload = {13'd0, cur_byte & LEAD2_PAYLOAD};
      end else if ((cur_byte & LEAD3_MASK) == LEAD3_TAG) begin
         f_count   = 1'b0;
         f_open    = 1'b1;
         f_len     = SEQ_LEN3;
         f_payload = {13'd0, cur_byte & LEAD3_PAYLOAD};
      end else if ((cur_byte & LEAD4_MASK) == LEAD4_TAG) begin
         f_count   = 1'b0;
         f_open    = 1'b1;
         f_len     = SEQ_LEN4;
         f_payload = {13'd0, cur_byte & LEAD4_PAYLOAD};
      end
   end

   // Full decode against the open sequence, and the next decoder state.
   always_comb begin
      held_plus   = {1'b0, held_ff} + 3'd1;
      cont_code   = {partial_ff[CODE_W-7:0], cur_byte[5:0]};
      is_cont     = (cur_byte & CONT_MASK) == CONT_TAG;
      dec_count   = '0;
      dec_code    = ILLEGAL_CODE;
      dec_illegal = 1'b1;
      held_in     = held_ff;
      expected_in = expected_ff;
      partial_in  = partial_ff;
      if (held_ff == 2'd0) begin
         dec_count   = {2'd0, f_count};
         dec_code    = f_code;
         dec_illegal = f_illegal;
         if (f_open) begin
            held_in     = 2'd1;
            expected_in = f_len;
            partial_in  = f_payload;
         end
      end else if (is_cont) begin
         if (held_plus >= expected_ff) begin
            // Sequence complete.
            dec_count   = 3'd1;
            dec_code    = cont_code;
            dec_illegal = 1'b0;
            held_in     = '0;
            expected_in = '0;
            partial_in  = '0;
         end else if (cur_last) begin
            // Text ends inside the sequence: every byte so far is illegal.
            dec_count   = held_plus;
            held_in     = '0;
            expected_in = '0;
            partial_in  = '0;
         end else begin
            held_in     = held_plus[1:0];
            partial_in  = cont_code;
         end
      end else begin
         // Broken sequence: flush the held bytes, then decode this byte fresh.
         dec_count = {1'b0, held_ff} + {2'd0, f_count};
         if (f_count) begin
            dec_code    = f_code;
            dec_illegal = f_illegal;
         end
         if (f_open) begin
            held_in     = 2'd1;
            expected_in = f_len;
            partial_in  = f_payload;
         end else begin
            held_in     = '0;
            expected_in = '0;
            partial_in  = '0;
         end
      end
   end

   // A byte with no results always moves on; one with results needs a free
   // burst register.
   assign advance   = in_valid_ff && (dec_count == 3'd0 || burst_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      burst_valid_in  = burst_valid_ff;
      burst_left_in   = burst_left_ff;
      tail_code_in    = tail_code_ff;
      tail_illegal_in = tail_illegal_ff;
      if (advance && dec_count != 3'd0) begin
         burst_valid_in  = 1'b1;
         burst_left_in   = dec_count;
         tail_code_in    = dec_code;
         tail_illegal_in = dec_illegal;
      end else if (rsp_take) begin
         if (burst_left_ff == 3'd1) begin
            burst_valid_in = 1'b0;
         end else begin
            burst_left_in  = burst_left_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         burst_valid_ff <= 1'b0;
         burst_left_ff  <= '0;
         held_ff        <= '0;
         expected_ff    <= '0;
         partial_ff     <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         burst_valid_ff <= burst_valid_in;
         burst_left_ff  <= burst_left_in;
         if (advance) begin
            held_ff     <= held_in;
            expected_ff <= expected_in;
            partial_ff  <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= req_data;
      end
      tail_code_ff    <= tail_code_in;
      tail_illegal_ff <= tail_illegal_in;
   end

   // Only the final beat of a burst carries the decoded value.
   assign rsp_valid = burst_valid_ff;
   always_comb begin
      if (burst_left_ff == 3'd1) begin
         rsp_data.code_point = tail_code_ff;
         rsp_data.is_illegal = tail_illegal_ff;
         rsp_data.run_end    = 1'b1;
      end else begin
         rsp_data.code_point = ILLEGAL_CODE;
         rsp_data.is_illegal = 1'b1;
         rsp_data.run_end    = 1'b0;
      end
   end

   `U8SD_ASSERT_IMPL(a_burst_range, clock, reset, burst_valid_ff, burst_left_ff >= 3'd1 && burst_left_ff <= 3'd4)
   `U8SD_ASSERT_IMPL(a_lead_beats_illegal, clock, reset, rsp_valid && !rsp_data.run_end, rsp_data.is_illegal && rsp_data.code_point == ILLEGAL_CODE)
   `U8SD_ASSERT_IMPL(a_open_seq_sane, clock, reset, held_ff != 2'd0, expected_ff >= SEQ_LEN2 && expected_ff <= SEQ_LEN4 && {1'b0, held_ff} < expected_ff)
   `U8SD_ASSERT_NEXT(a_burst_countdown, clock, reset, rsp_take && burst_left_ff > 3'd1, burst_valid_ff && burst_left_ff == $past(burst_left_ff) - 3'd1)

endmodule
